FILE: sv/odo_pkg.sv
// Shared constants, types and tables of the three-wheel odometry pose unit.
package odo_pkg;

    // Iteration count of the rotation unit and significant encoder count bits.
    localparam int CORDIC_STEPS = 24;
    localparam int COUNT_BITS   = 32;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_DIST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROFF = 2'd2;

    // Register reset values.
    localparam logic [31:0] DIST_RESET = 32'd103071816;
    localparam logic [23:0] HEAD_RESET = 24'd1773448;
    localparam logic [19:0] ROFF_RESET = 20'd21255;

    // Reciprocal of the rotation gain, unsigned Q0.32.
    localparam logic [31:0] INV_GAIN = 32'd2608131496;

    // Datapath operations, one per controller step.
    typedef enum logic [4:0] {
        OP_IDLE, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_M6, OP_M7,
        OP_ROT, OP_G1, OP_G2, OP_G3, OP_G4, OP_G5, OP_SAT, OP_FIN
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              take;
        logic              load_out;
        logic [ITER_W-1:0] iter;
    } dp_cmd_t;

    typedef struct packed {
        logic clear;
    } dp_stat_t;

    // Arctangent of 2^-i as a binary angle.
    function automatic logic [31:0] atan_ba(input logic [4:0] idx);
        logic [31:0] v;
        begin
            unique case (idx)
                5'd0:  v = 32'h20000000;
                5'd1:  v = 32'h12E4051E;
                5'd2:  v = 32'h09FB385B;
                5'd3:  v = 32'h051111D4;
                5'd4:  v = 32'h028B0D43;
                5'd5:  v = 32'h0145D7E1;
                5'd6:  v = 32'h00A2F61E;
                5'd7:  v = 32'h00517C55;
                5'd8:  v = 32'h0028BE53;
                5'd9:  v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;
                5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;
                5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2FA;
                5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE;
                5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30;
                5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C;
                5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3;
                5'd23: v = 32'h00000051;
                5'd24: v = 32'h00000029;
                5'd25: v = 32'h00000014;
                5'd26: v = 32'h0000000A;
                5'd27: v = 32'h00000005;
                5'd28: v = 32'h00000003;
                5'd29: v = 32'h00000001;
                5'd30: v = 32'h00000001;
                5'd31: v = 32'h00000000;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: sv/odo_if.sv
// Request and result channel interfaces of the odometry pose unit.
interface odo_req_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic signed [31:0] rear_count;

    modport source (output valid, command, left_count, right_count, rear_count,
                    input ready);
    modport sink   (input valid, command, left_count, right_count, rear_count,
                    output ready);
endinterface

interface odo_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [31:0] heading;
    logic               saturated;

    modport source (output valid, pos_x, pos_y, heading, saturated, input ready);
    modport sink   (input valid, pos_x, pos_y, heading, saturated, output ready);
endinterface

FILE: sv/odo_ctrl.sv
// Step sequencer of the odometry pose unit.
module odo_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  odo_pkg::dp_stat_t stat,
    output odo_pkg::dp_cmd_t  cmd
);
    import odo_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7,
        ST_ROT, ST_G1, ST_G2, ST_G3, ST_G4, ST_G5, ST_SAT, ST_FIN
    } state_t;

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

    state_t            state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic              load_out;

    // Next state and result handshake.
    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        load_out       = 1'b0;
        unique case (state_reg)
            ST_IDLE: if (req_valid) state_next = ST_M1;
            ST_M1:   state_next = stat.clear ? ST_FIN : ST_M2;
            ST_M2:   state_next = ST_M3;
            ST_M3:   state_next = ST_M4;
            ST_M4:   state_next = ST_M5;
            ST_M5:   state_next = ST_M6;
            ST_M6:   state_next = ST_M7;
            ST_M7:
            begin
                iter_next  = '0;
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                if (iter_reg == ITER_LAST)
                    state_next = ST_G1;
                else
                    iter_next = iter_reg + 1'b1;
            end
            ST_G1:   state_next = ST_G2;
            ST_G2:   state_next = ST_G3;
            ST_G3:   state_next = ST_G4;
            ST_G4:   state_next = ST_G5;
            ST_G5:   state_next = ST_SAT;
            ST_SAT:  state_next = ST_FIN;
            ST_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    load_out       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Operation decode for the datapath.
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: cmd.op = OP_IDLE;
            ST_M1:   cmd.op = OP_M1;
            ST_M2:   cmd.op = OP_M2;
            ST_M3:   cmd.op = OP_M3;
            ST_M4:   cmd.op = OP_M4;
            ST_M5:   cmd.op = OP_M5;
            ST_M6:   cmd.op = OP_M6;
            ST_M7:   cmd.op = OP_M7;
            ST_ROT:  cmd.op = OP_ROT;
            ST_G1:   cmd.op = OP_G1;
            ST_G2:   cmd.op = OP_G2;
            ST_G3:   cmd.op = OP_G3;
            ST_G4:   cmd.op = OP_G4;
            ST_G5:   cmd.op = OP_G5;
            ST_SAT:  cmd.op = OP_SAT;
            ST_FIN:  cmd.op = OP_FIN;
            default: cmd.op = OP_IDLE;
        endcase
        cmd.take     = (state_reg == ST_IDLE) && req_valid;
        cmd.load_out = load_out;
        cmd.iter     = iter_reg;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

FILE: sv/odo_dpath.sv
// Datapath of the odometry pose unit: deltas, shared multiplier, rotation, pose.
module odo_dpath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  odo_pkg::dp_cmd_t                 cmd,
    output odo_pkg::dp_stat_t                stat,
    input  logic                             cfg_we,
    input  logic [odo_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [odo_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_command,
    input  logic signed [31:0]               in_left,
    input  logic signed [31:0]               in_right,
    input  logic signed [31:0]               in_rear,
    output logic signed [31:0]               pos_x,
    output logic signed [31:0]               pos_y,
    output logic        [31:0]               heading,
    output logic                             saturated
);
    import odo_pkg::*;

    localparam int CB   = COUNT_BITS;
    localparam int D_W  = CB + 1;
    localparam int MA_W = 33;
    localparam int MB_W = 32;
    localparam int MP_W = MA_W + MB_W;
    localparam int LC_W = 56;
    localparam int W    = 64;
    localparam int Z_W  = 34;

    localparam logic signed [Z_W-1:0] Z_QTR  = 34'sh0_4000_0000;
    localparam logic signed [Z_W-1:0] Z_HALF = 34'sh0_8000_0000;
    localparam logic signed [64:0]    S_MAX  = 65'sd2147483647;
    localparam logic signed [64:0]    S_MIN  = -65'sd2147483648;

    // Configuration and pose state.
    logic [31:0]        dist_reg;
    logic [23:0]        head_reg;
    logic [19:0]        roff_reg;
    logic [CB-1:0]      prev_l_reg, prev_r_reg, prev_b_reg;
    logic signed [31:0] acc_x_reg, acc_y_reg;
    logic [31:0]        acc_hd_reg;
    logic               clip_reg;

    // Working registers.
    logic                    cmd_reg;
    logic signed [D_W-1:0]   sum_reg, diff_reg;
    logic signed [CB-1:0]    db_reg;
    logic [32:0]             dth_reg;
    logic signed [W-1:0]     fwd_reg;
    logic [LC_W-1:0]         latc_mag_reg;
    logic                    lat_neg_reg;
    logic [32:0]             lo_reg;
    logic signed [W-1:0]     x_reg, y_reg, xr_reg, yr_reg;
    logic signed [Z_W-1:0]   z_reg;
    logic [MP_W-1:0]         prod_reg;

    // Count deltas, read as signed values modulo the count range.
    logic [CB-1:0]         cur_l, cur_r, cur_b;
    logic signed [CB-1:0]  dl, dr, db;
    logic signed [D_W-1:0] sum_c, diff_c;
    assign cur_l  = in_left[CB-1:0];
    assign cur_r  = in_right[CB-1:0];
    assign cur_b  = in_rear[CB-1:0];
    assign dl     = cur_l - prev_l_reg;
    assign dr     = cur_r - prev_r_reg;
    assign db     = cur_b - prev_b_reg;
    assign sum_c  = D_W'(dl) + D_W'(dr);
    assign diff_c = D_W'(dr) - D_W'(dl);

    // Magnitudes feeding the unsigned multiplier.
    logic [D_W-1:0] sum_mag, diff_mag;
    logic [W-1:0]   x_mag, y_mag;
    assign sum_mag  = sum_reg[D_W-1] ? D_W'(-sum_reg) : D_W'(sum_reg);
    assign diff_mag = diff_reg[D_W-1] ? D_W'(-diff_reg) : D_W'(diff_reg);
    assign x_mag    = x_reg[W-1] ? W'(-x_reg) : W'(x_reg);
    assign y_mag    = y_reg[W-1] ? W'(-y_reg) : W'(y_reg);

    // Lateral numerator: rear delta in Q16 less the rotation part.
    logic signed [LC_W-1:0] rot_term, latc;
    assign rot_term = diff_reg[D_W-1] ? -LC_W'(prod_reg[52:0]) : LC_W'(prod_reg[52:0]);
    assign latc     = (LC_W'(db_reg) <<< 16) - rot_term;

    // Midpoint heading folded into the right half plane.
    logic [31:0]           ang;
    logic signed [Z_W-1:0] z_raw, z_fold;
    logic                  flip;
    assign ang   = acc_hd_reg + dth_reg[32:1];
    assign z_raw = Z_W'($signed(ang));
    always_comb
    begin
        z_fold = z_raw;
        flip   = 1'b0;
        if (z_raw > Z_QTR)
        begin
            z_fold = z_raw - Z_HALF;
            flip   = 1'b1;
        end
        else if (z_raw < -Z_QTR)
        begin
            z_fold = z_raw + Z_HALF;
            flip   = 1'b1;
        end
    end

    // Assembled magnitudes from the two partial products.
    logic [W-1:0] pp_sum;
    assign pp_sum = prod_reg[W-1:0] + W'(lo_reg);

    // One rotation step.
    logic signed [W-1:0]   x_sh, y_sh;
    logic signed [Z_W-1:0] atan_v;
    assign x_sh   = x_reg >>> cmd.iter;
    assign y_sh   = y_reg >>> cmd.iter;
    assign atan_v = Z_W'(atan_ba(5'(cmd.iter)));

    // Saturating position update.
    logic signed [64:0] sx, sy;
    logic               clip_x, clip_y;
    logic signed [31:0] nx, ny;
    assign sx = 65'(acc_x_reg) + 65'(xr_reg);
    assign sy = 65'(acc_y_reg) + 65'(yr_reg);
    always_comb
    begin
        clip_x = 1'b1;
        clip_y = 1'b1;
        if (sx > S_MAX)      nx = 32'sh7FFFFFFF;
        else if (sx < S_MIN) nx = 32'sh80000000;
        else
        begin
            nx     = 32'(sx);
            clip_x = 1'b0;
        end
        if (sy > S_MAX)      ny = 32'sh7FFFFFFF;
        else if (sy < S_MIN) ny = 32'sh80000000;
        else
        begin
            ny     = 32'(sy);
            clip_y = 1'b0;
        end
    end

    // Operand select of the shared multiplier.
    logic [MA_W-1:0] mul_a;
    logic [MB_W-1:0] mul_b;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_M1:
            begin
                mul_a = MA_W'(diff_reg);
                mul_b = MB_W'(head_reg);
            end
            OP_M2:
            begin
                mul_a = MA_W'(sum_mag);
                mul_b = dist_reg;
            end
            OP_M3:
            begin
                mul_a = MA_W'(diff_mag);
                mul_b = MB_W'(roff_reg);
            end
            OP_M5:
            begin
                mul_a = MA_W'(latc_mag_reg[31:0]);
                mul_b = dist_reg;
            end
            OP_M6:
            begin
                mul_a = MA_W'(latc_mag_reg[LC_W-1:32]);
                mul_b = dist_reg;
            end
            OP_G1:
            begin
                mul_a = MA_W'(x_mag[31:0]);
                mul_b = INV_GAIN;
            end
            OP_G2:
            begin
                mul_a = MA_W'(x_mag[W-1:32]);
                mul_b = INV_GAIN;
            end
            OP_G3:
            begin
                mul_a = MA_W'(y_mag[31:0]);
                mul_b = INV_GAIN;
            end
            OP_G4:
            begin
                mul_a = MA_W'(y_mag[W-1:32]);
                mul_b = INV_GAIN;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Working registers, stepped by the controller.
    always_ff @(posedge clk)
    begin
        prod_reg <= MP_W'(mul_a) * MP_W'(mul_b);
        unique case (cmd.op)
            OP_IDLE:
            begin
                if (cmd.take)
                begin
                    cmd_reg  <= in_command;
                    sum_reg  <= sum_c;
                    diff_reg <= diff_c;
                    db_reg   <= db;
                end
            end
            OP_M2: dth_reg <= prod_reg[32:0];
            OP_M3:
            begin
                fwd_reg <= sum_reg[D_W-1] ? -W'(prod_reg[MP_W-1:17])
                                          : W'(prod_reg[MP_W-1:17]);
            end
            OP_M4:
            begin
                latc_mag_reg <= latc[LC_W-1] ? LC_W'(-latc) : LC_W'(latc);
                lat_neg_reg  <= latc[LC_W-1];
            end
            OP_M6: lo_reg <= prod_reg[MP_W-1:32];
            OP_M7:
            begin
                x_reg <= flip ? -fwd_reg : fwd_reg;
                y_reg <= (flip ^ lat_neg_reg) ? -W'(pp_sum) : W'(pp_sum);
                z_reg <= z_fold;
            end
            OP_ROT:
            begin
                if (!z_reg[Z_W-1])
                begin
                    x_reg <= x_reg - y_sh;
                    y_reg <= y_reg + x_sh;
                    z_reg <= z_reg - atan_v;
                end
                else
                begin
                    x_reg <= x_reg + y_sh;
                    y_reg <= y_reg - x_sh;
                    z_reg <= z_reg + atan_v;
                end
            end
            OP_G2: lo_reg <= prod_reg[MP_W-1:32];
            OP_G3: xr_reg <= x_reg[W-1] ? -W'(pp_sum) : W'(pp_sum);
            OP_G4: lo_reg <= prod_reg[MP_W-1:32];
            OP_G5: yr_reg <= y_reg[W-1] ? -W'(pp_sum) : W'(pp_sum);
            default:
            begin
            end
        endcase
    end

    // Configuration, reference counts, pose and result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg   <= DIST_RESET;
            head_reg   <= HEAD_RESET;
            roff_reg   <= ROFF_RESET;
            prev_l_reg <= '0;
            prev_r_reg <= '0;
            prev_b_reg <= '0;
            acc_x_reg  <= '0;
            acc_y_reg  <= '0;
            acc_hd_reg <= '0;
            clip_reg   <= 1'b0;
            pos_x      <= '0;
            pos_y      <= '0;
            heading    <= '0;
            saturated  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_DIST)      dist_reg <= cfg_data[31:0];
                else if (cfg_index == REG_HEAD) head_reg <= cfg_data[23:0];
                else if (cfg_index == REG_ROFF) roff_reg <= cfg_data[19:0];
            end
            if (cmd.take)
            begin
                prev_l_reg <= cur_l;
                prev_r_reg <= cur_r;
                prev_b_reg <= cur_b;
                if (in_command)
                begin
                    acc_x_reg  <= '0;
                    acc_y_reg  <= '0;
                    acc_hd_reg <= '0;
                    clip_reg   <= 1'b0;
                end
            end
            if (cmd.op == OP_SAT)
            begin
                acc_x_reg  <= nx;
                acc_y_reg  <= ny;
                acc_hd_reg <= acc_hd_reg + dth_reg[31:0];
                clip_reg   <= clip_x | clip_y;
            end
            if (cmd.load_out)
            begin
                pos_x     <= acc_x_reg;
                pos_y     <= acc_y_reg;
                heading   <= acc_hd_reg;
                saturated <= clip_reg;
            end
        end
    end

    assign stat.clear = cmd_reg;

endmodule

FILE: sv/three_wheel_odometry_pose_unit.sv
// Top level of the three-tracking-wheel odometry pose unit.
// Each request carries the absolute left, right and rear encoder counts and a
// command bit; one result with the updated Q16.16 position, the binary-angle
// heading and a clip flag comes back per request. An update request runs
// 7 steps through one shared 33x32 multiplier for the deltas and scaling,
// CORDIC_STEPS (24) iterations of the rotation unit, 5 steps for the gain
// correction, then the saturating add and the result load. A clear request
// goes from its first step straight to the result load. A
// finished result waits in the output register while the next request is
// accepted; the block stalls at its last step only if that result is still
// not taken. Configuration writes take effect at once and must only be made
// while no request is in progress.
module three_wheel_odometry_pose_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    odo_req_if.sink                         req,
    odo_rsp_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [odo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [odo_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import odo_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Step sequencer.
    odo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Arithmetic and pose state.
    odo_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_command (req.command),
        .in_left    (req.left_count),
        .in_right   (req.right_count),
        .in_rear    (req.rear_count),
        .pos_x      (rsp.pos_x),
        .pos_y      (rsp.pos_y),
        .heading    (rsp.heading),
        .saturated  (rsp.saturated)
    );

    // One request at a time: acceptance closes the request side.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while another is in progress");

    // A result only appears at the end of a request, never from idle.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(!req.ready))
        else $error("result raised while idle");

    // A clipped result sits on a position limit.
    a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.saturated |->
            (rsp.pos_x == 32'sh7FFFFFFF || rsp.pos_x == 32'sh80000000 ||
             rsp.pos_y == 32'sh7FFFFFFF || rsp.pos_y == 32'sh80000000))
        else $error("clip flag set without a position at its limit");

endmodule
